/* hdl/mspc_pkg.sv */
// Shared constants, register codes, state encoding and status types for the
// motor speed PID controller. No dependencies; the divider and the top level import it.
`timescale 1ns / 1ps

package mspc_pkg;

    localparam int unsigned FIELD_W    = 16;
    localparam int unsigned SCALE_W    = 32;
    localparam int unsigned DIST_W     = 32;
    localparam int unsigned CMD_W      = 17;
    localparam int unsigned ERR_W      = 17;
    localparam int unsigned OPND_W     = 18;
    localparam int unsigned PROD_W     = 34;
    localparam int unsigned SUM_W      = 36;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned DIV_STEPS  = SCALE_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int unsigned MUL_STEPS  = FIELD_W;
    localparam int unsigned MUL_CNT_W  = $clog2(MUL_STEPS);
    localparam int unsigned GAIN_LANES = 3;

    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 32'd25000000;
    localparam logic [FIELD_W-1:0] SPEED_MAX       = 16'hFFFF;
    localparam logic [CMD_W-1:0]   CMD_MAX         = 17'd100000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_SCALE = 3'd0,
        CFG_WHEEL_DIST  = 3'd1,
        CFG_PROP_GAIN   = 3'd2,
        CFG_INT_GAIN    = 3'd3,
        CFG_DERIV_GAIN  = 3'd4
    } mspc_cfg_idx_t;

    // Gain lanes of the serial multiplier.
    typedef enum logic [1:0] {
        LANE_PROP  = 2'd0,
        LANE_INT   = 2'd1,
        LANE_DERIV = 2'd2
    } mspc_lane_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ERR,
        ST_MUL,
        ST_SUM,
        ST_DONE
    } mspc_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mspc_div_stat_t;

endpackage

/* hdl/mspc_if.sv */
// Valid/ready channel interfaces for the speed controller: the measurement
// item going in and the result item coming out. Widths are fixed by the item fields.
`timescale 1ns / 1ps

interface mspc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] period_ticks;
    logic [15:0] revolutions;
    logic [15:0] target_speed;

    modport source (output valid, output period_ticks, output revolutions,
                    output target_speed, input ready);
    modport sink   (input valid, input period_ticks, input revolutions,
                    input target_speed, output ready);
endinterface

interface mspc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] speed_rpm;
    logic [31:0] distance;
    logic [16:0] drive_command;
    logic        period_invalid;

    modport source (output valid, output speed_rpm, output distance,
                    output drive_command, output period_invalid, input ready);
    modport sink   (input valid, input speed_rpm, input distance,
                    input drive_command, input period_invalid, output ready);
endinterface

/* hdl/mspc_div.sv */
// Bit-serial restoring divider: 32-bit dividend by 16-bit divisor, one
// quotient bit per cycle. Depends on mspc_pkg.
`timescale 1ns / 1ps

module mspc_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [mspc_pkg::SCALE_W-1:0]      dividend,
    input  logic [mspc_pkg::FIELD_W-1:0]      divisor,
    output logic [mspc_pkg::SCALE_W-1:0]      quotient,
    output mspc_pkg::mspc_div_stat_t          stat
);
    import mspc_pkg::*;

    logic [FIELD_W-1:0]   rem_reg;
    logic [SCALE_W-1:0]   quo_reg;
    logic [FIELD_W-1:0]   div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [FIELD_W:0]     trial;
    logic [FIELD_W:0]     diff;
    logic                 ge;
    logic [FIELD_W-1:0]   rem_step;

    // For a nonzero divisor the partial remainder always stays below the divisor, so the
    // difference fits back into FIELD_W bits.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[SCALE_W-1]};
        diff     = trial - {1'b0, div_reg};
        ge       = (trial >= {1'b0, div_reg});
        rem_step = ge ? diff[FIELD_W-1:0] : trial[FIELD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[SCALE_W-2:0], ge};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* hdl/motor_speed_pid_clamped.sv */
// Top level of the motor speed PID controller with clamped drive command.
// Depends on mspc_pkg, the channel interfaces in mspc_if and the divider mspc_div.
`timescale 1ns / 1ps

// Channel   Kind              Item contents
// -------   ---------------   ---------------------------------------------
// sample    valid/ready in    period_ticks, revolutions, target_speed
// report    valid/ready out   speed_rpm, distance, drive_command, period_invalid
// cfg       write-only port   cfg_we, cfg_index, cfg_wdata (5 registers)
//
// An item passes from acceptance to a valid result through the bit-serial
// divider, the hand-over of its done flag to the controller, the error step,
// the shift-and-add multiplier lanes, then the sum and the clamp stage. One
// item is in flight at a time, so no item is accepted before the last one is
// through; the next item is taken once the result is in the output register,
// even while that result still waits on report.ready. Reset is asynchronous and
// active low; it clears control state, the stored last error and restores the
// register defaults.

module motor_speed_pid_clamped (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mspc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mspc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    mspc_in_if.sink                             sample,
    mspc_out_if.source                          report
);
    import mspc_pkg::*;

    // Configuration registers.
    logic [SCALE_W-1:0] speed_scale_reg;
    logic [FIELD_W-1:0] wheel_dist_reg;
    logic [FIELD_W-1:0] prop_gain_reg;
    logic [FIELD_W-1:0] int_gain_reg;
    logic [FIELD_W-1:0] deriv_gain_reg;

    // Control state.
    mspc_state_t          state_reg;
    mspc_state_t          state_next;
    logic [MUL_CNT_W-1:0] mul_cnt_reg;
    logic                 out_valid_reg;

    // Latched item fields and intermediate values.
    logic                      invalid_reg;
    logic [FIELD_W-1:0]        revs_reg;
    logic [FIELD_W-1:0]        target_reg;
    logic [FIELD_W-1:0]        speed_reg;
    logic signed [ERR_W-1:0]   last_err_reg;
    logic signed [SUM_W-1:0]   sum_reg;

    // Multiplier lanes: the three gain products and the distance product.
    logic signed [PROD_W-1:0]  mcand_reg  [GAIN_LANES];
    logic [FIELD_W-1:0]        mplier_reg [GAIN_LANES];
    logic signed [PROD_W-1:0]  acc_reg    [GAIN_LANES];
    logic [DIST_W-1:0]         dmcand_reg;
    logic [FIELD_W-1:0]        dmplier_reg;
    logic [DIST_W-1:0]         dacc_reg;

    // Output register.
    logic [FIELD_W-1:0]        out_speed_reg;
    logic [DIST_W-1:0]         out_dist_reg;
    logic [CMD_W-1:0]          out_cmd_reg;
    logic                      out_invalid_reg;

    // Divider hookup.
    logic                      div_start;
    logic [SCALE_W-1:0]        div_quo;
    mspc_div_stat_t            div_stat;

    logic                      in_ready;
    logic                      out_free;
    logic                      load_out;
    logic [FIELD_W-1:0]        speed_val;
    logic signed [ERR_W-1:0]   err_val;
    logic signed [OPND_W-1:0]  sum_opnd;
    logic signed [OPND_W-1:0]  diff_opnd;
    logic [CMD_W-1:0]          cmd_val;

    mspc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (speed_scale_reg),
        .divisor  (sample.period_ticks),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // Writes to an index beyond the last register are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_scale_reg <= SPEED_SCALE_RST;
            wheel_dist_reg  <= '0;
            prop_gain_reg   <= '0;
            int_gain_reg    <= '0;
            deriv_gain_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SPEED_SCALE: speed_scale_reg <= cfg_wdata[SCALE_W-1:0];
                CFG_WHEEL_DIST:  wheel_dist_reg  <= cfg_wdata[FIELD_W-1:0];
                CFG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata[FIELD_W-1:0];
                CFG_INT_GAIN:    int_gain_reg    <= cfg_wdata[FIELD_W-1:0];
                CFG_DERIV_GAIN:  deriv_gain_reg  <= cfg_wdata[FIELD_W-1:0];
                default:         ;
            endcase
        end
    end

    // The output register can take a new result when it is empty or its
    // current result leaves in this cycle.
    assign out_free = !out_valid_reg || report.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (sample.valid)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_cnt_reg == '0)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Speed saturates when the quotient needs more than 16 bits; a zero
    // period forces speed to zero, and the error is then the full target.
    always_comb
    begin
        if (invalid_reg)
        begin
            speed_val = '0;
        end
        else if (div_quo[SCALE_W-1:FIELD_W] != '0)
        begin
            speed_val = SPEED_MAX;
        end
        else
        begin
            speed_val = div_quo[FIELD_W-1:0];
        end
        err_val   = signed'({1'b0, target_reg}) - signed'({1'b0, speed_val});
        sum_opnd  = OPND_W'(last_err_reg) + OPND_W'(err_val);
        diff_opnd = OPND_W'(last_err_reg) - OPND_W'(err_val);
    end

    // Clamp the command sum into 0..CMD_MAX.
    always_comb
    begin
        if (sum_reg[SUM_W-1])
        begin
            cmd_val = '0;
        end
        else if (sum_reg > SUM_W'(CMD_MAX))
        begin
            cmd_val = CMD_MAX;
        end
        else
        begin
            cmd_val = sum_reg[CMD_W-1:0];
        end
    end

    // The last error is replaced in the same edge that reads its old value
    // into the integral and derivative operands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg <= '0;
            mul_cnt_reg  <= '0;
        end
        else if (state_reg == ST_ERR)
        begin
            last_err_reg <= err_val;
            mul_cnt_reg  <= MUL_CNT_W'(MUL_STEPS - 1);
        end
        else if (state_reg == ST_MUL)
        begin
            mul_cnt_reg <= mul_cnt_reg - 1'b1;
        end
    end

    // Item capture and the shift-and-add lanes. Each cycle of the multiply
    // phase looks at one multiplier bit per lane.
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            invalid_reg <= (sample.period_ticks == '0);
            revs_reg    <= sample.revolutions;
            target_reg  <= sample.target_speed;
        end
        case (state_reg)
            ST_ERR:
            begin
                speed_reg              <= speed_val;
                mcand_reg[LANE_PROP]   <= PROD_W'(err_val);
                mcand_reg[LANE_INT]    <= PROD_W'(sum_opnd);
                mcand_reg[LANE_DERIV]  <= PROD_W'(diff_opnd);
                mplier_reg[LANE_PROP]  <= prop_gain_reg;
                mplier_reg[LANE_INT]   <= int_gain_reg;
                mplier_reg[LANE_DERIV] <= deriv_gain_reg;
                for (int i = 0; i < GAIN_LANES; i++)
                begin
                    acc_reg[i] <= '0;
                end
                dmcand_reg  <= DIST_W'(revs_reg);
                dmplier_reg <= wheel_dist_reg;
                dacc_reg    <= '0;
            end
            ST_MUL:
            begin
                for (int i = 0; i < GAIN_LANES; i++)
                begin
                    if (mplier_reg[i][0])
                    begin
                        acc_reg[i] <= acc_reg[i] + mcand_reg[i];
                    end
                    mcand_reg[i]  <= mcand_reg[i] <<< 1;
                    mplier_reg[i] <= mplier_reg[i] >> 1;
                end
                if (dmplier_reg[0])
                begin
                    dacc_reg <= dacc_reg + dmcand_reg;
                end
                dmcand_reg  <= dmcand_reg << 1;
                dmplier_reg <= dmplier_reg >> 1;
            end
            ST_SUM:
            begin
                sum_reg <= SUM_W'(acc_reg[LANE_PROP]) + SUM_W'(acc_reg[LANE_INT])
                         + SUM_W'(acc_reg[LANE_DERIV]);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_speed_reg   <= speed_reg;
            out_dist_reg    <= dacc_reg;
            out_cmd_reg     <= cmd_val;
            out_invalid_reg <= invalid_reg;
        end
    end

    assign sample.ready          = in_ready;
    assign report.valid          = out_valid_reg;
    assign report.speed_rpm      = out_speed_reg;
    assign report.distance       = out_dist_reg;
    assign report.drive_command  = out_cmd_reg;
    assign report.period_invalid = out_invalid_reg;

    // An accepted item always starts the divider.
    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> div_stat.busy)
        else $error("accepted item did not start the divider");

    // The divider only finishes while the controller waits for it.
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    // The drive command never leaves its clamp range.
    a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
        report.valid |-> (report.drive_command <= CMD_MAX))
        else $error("drive command above its limit");

    // A zero period always reports zero speed.
    a_invalid_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (report.valid && report.period_invalid) |-> (report.speed_rpm == '0))
        else $error("invalid period reported with nonzero speed");

endmodule
